### hw/rtl/single_wire_frame_transceiver_top_macros.svh
// Assertion helpers used by the checker of the transceiver.
`ifndef SINGLE_WIRE_FRAME_TRANSCEIVER_TOP_MACROS_SVH
`define SINGLE_WIRE_FRAME_TRANSCEIVER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWFT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swft check failed");

// Next-cycle implication, disabled during reset.
`define SWFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swft check failed");

`endif

### hw/rtl/swft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package swft_pkg;

  // Receive ring geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Frame timing in half-bit ticks
  localparam logic [4:0] TICK_FIRST_SAMPLE = 5'd3;
  localparam logic [4:0] TICK_LAST_SAMPLE  = 5'd17;
  localparam logic [4:0] TICK_END          = 5'd18;

  // Transaction mode codes
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_EDGE  = 3'd1;
  localparam logic [2:0] MODE_SEND  = 3'd2;
  localparam logic [2:0] MODE_POP   = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;

  // Advance a ring index with wrap at the depth
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W:0] inc;
    inc = {1'b0, i} + (IDX_W+1)'(1);
    next_idx = (inc == (IDX_W+1)'(DEPTH)) ? '0 : inc[IDX_W-1:0];
  endfunction

  // Number of bytes held between read and write index
  function automatic logic [CNT_W-1:0] stored_count(input logic [IDX_W-1:0] ri,
                                                    input logic [IDX_W-1:0] wi);
    logic [IDX_W-1:0] diff;
    if (wi >= ri) begin
      diff = wi - ri;
      stored_count = CNT_W'(diff);
    end else begin
      diff = ri - wi;
      stored_count = CNT_W'(DEPTH) - CNT_W'(diff);
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/swft_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module swft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port that holds when not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/single_wire_frame_transceiver_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Single-wire half-duplex byte link with a 16-entry receive ring.
// Input channel (in_valid / in_stall) carries one transaction per event:
// a half-bit tick with the sampled bus level, a bus falling edge, a send
// request with tx_byte, a pop or a clear. Every transaction yields exactly
// one result on the output channel (out_valid / out_stall) with the bus
// drive, accept flag, popped byte, stored count and busy status.
// out_valid rises in the cycle after the accept; throughput is one
// transaction per cycle while out_stall is low. Popped bytes come
// from the ring RAM's registered read port, issued in the accept cycle
// and aligned with the output register; back-to-back pops run at full rate.
// While the receiver stalls, the result and the RAM read data hold and
// in_stall is raised; a new transaction enters in the same cycle the
// pending result is taken.
// Reset (rst, synchronous) idles the link and empties the ring by zeroing
// both indices; ring contents need no clearing pass.
module single_wire_frame_transceiver_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [2:0] mode,
  input  wire logic       bus_level,
  input  wire logic [7:0] tx_byte,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       bus_pull_low,
  output      logic       accepted,
  output      logic [7:0] rx_byte,
  output      logic       rx_valid,
  output      logic [3:0] msg_count,
  output      logic       busy_res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RX,
    PH_TX
  } phase_t;

  phase_t                       phase, phase_next;
  logic [4:0]                   tick_count, tick_count_next, tick_inc;
  logic [7:0]                   rx_shift, rx_shift_next;
  logic [7:0]                   tx_shift, tx_shift_next;
  logic                         line_low, line_low_next;
  logic [swft_pkg::IDX_W-1:0]   read_index, read_index_next;
  logic [swft_pkg::IDX_W-1:0]   write_index, write_index_next;
  logic                         accepted_next, rx_valid_next;
  logic [swft_pkg::CNT_W-1:0]   count_next;
  logic                         take;
  logic                         ram_we, ram_re;
  logic [7:0]                   ram_rdata;

  // Accept when the output register is free or being drained
  assign in_stall = out_valid & out_stall;
  assign take     = in_valid & ~in_stall;
  assign tick_inc = tick_count + 5'd1;

  // Next state of the link and ring indices
  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    rx_shift_next    = rx_shift;
    tx_shift_next    = tx_shift;
    line_low_next    = line_low;
    read_index_next  = read_index;
    write_index_next = write_index;
    accepted_next    = 1'b0;
    rx_valid_next    = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    unique case (mode)
      swft_pkg::MODE_TICK: begin
        if (phase != PH_IDLE) begin
          tick_count_next = tick_inc;
          if (phase == PH_RX) begin
            if (tick_inc[0] && tick_inc >= swft_pkg::TICK_FIRST_SAMPLE &&
                tick_inc <= swft_pkg::TICK_LAST_SAMPLE) begin
              rx_shift_next = {rx_shift[6:0], bus_level};
            end else if (tick_inc == swft_pkg::TICK_END) begin
              ram_we = 1'b1;
              if (swft_pkg::next_idx(write_index) != read_index) begin
                write_index_next = swft_pkg::next_idx(write_index);
              end
              phase_next    = PH_IDLE;
              line_low_next = 1'b0;
            end
          end else begin
            if (tick_inc == swft_pkg::TICK_END) begin
              phase_next    = PH_IDLE;
              line_low_next = 1'b0;
            end else if (!tick_inc[0]) begin
              line_low_next = ~tx_shift[7];
              tx_shift_next = {tx_shift[6:0], 1'b0};
            end
          end
        end
      end
      swft_pkg::MODE_EDGE: begin
        if (phase == PH_IDLE) begin
          phase_next      = PH_RX;
          tick_count_next = '0;
          accepted_next   = 1'b1;
        end
      end
      swft_pkg::MODE_SEND: begin
        if (phase == PH_IDLE) begin
          phase_next      = PH_TX;
          tick_count_next = '0;
          tx_shift_next   = tx_byte;
          line_low_next   = 1'b1;
          accepted_next   = 1'b1;
        end
      end
      swft_pkg::MODE_POP: begin
        if (read_index != write_index) begin
          ram_re          = 1'b1;
          rx_valid_next   = 1'b1;
          read_index_next = swft_pkg::next_idx(read_index);
        end
      end
      swft_pkg::MODE_CLEAR: begin
        read_index_next  = '0;
        write_index_next = '0;
      end
      default: begin
      end
    endcase
    // A clear reports what it discarded
    if (mode == swft_pkg::MODE_CLEAR) begin
      count_next = swft_pkg::stored_count(read_index, write_index);
    end else begin
      count_next = swft_pkg::stored_count(read_index_next, write_index_next);
    end
    ram_we = ram_we & take;
    ram_re = ram_re & take;
  end

  // Hold link state and the output register, load the result payload
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_count  <= '0;
      rx_shift    <= '0;
      tx_shift    <= '0;
      line_low    <= 1'b0;
      read_index  <= '0;
      write_index <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        phase        <= phase_next;
        tick_count   <= tick_count_next;
        rx_shift     <= rx_shift_next;
        tx_shift     <= tx_shift_next;
        line_low     <= line_low_next;
        read_index   <= read_index_next;
        write_index  <= write_index_next;
        out_valid    <= 1'b1;
        bus_pull_low <= line_low_next;
        accepted     <= accepted_next;
        rx_valid     <= rx_valid_next;
        msg_count    <= count_next[3:0];
        busy_res     <= (phase_next != PH_IDLE);
      end else if (!out_stall) begin
        out_valid    <= 1'b0;
      end
    end
  end

  assign rx_byte = rx_valid ? ram_rdata : 8'd0;

  // Receive ring storage
  swft_ram #(
    .WIDTH (8),
    .DEPTH (swft_pkg::DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_index),
    .wdata (rx_shift),
    .re    (ram_re),
    .raddr (read_index),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

### hw/rtl/swft_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "single_wire_frame_transceiver_top_macros.svh"
module swft_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       bus_pull_low,
  input wire logic       accepted,
  input wire logic [7:0] rx_byte,
  input wire logic       rx_valid,
  input wire logic       busy_res
);

  // A stalled result transaction stays and keeps its byte
  `SWFT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(rx_byte))
  // No pop result means a zero byte
  `SWFT_ASSERT_IMPL(a_no_pop_zero, clk, rst, out_valid && !rx_valid, rx_byte == 8'd0)
  // The bus is driven only while a frame is in flight
  `SWFT_ASSERT_IMPL(a_drive_busy, clk, rst, out_valid && bus_pull_low, busy_res)
  // An accepted edge or send starts a frame
  `SWFT_ASSERT_IMPL(a_accept_busy, clk, rst, out_valid && accepted, busy_res && !rx_valid)
  // Input is held off only while a result waits
  `SWFT_ASSERT_IMPL(a_stall_src, clk, rst, in_stall, out_valid && out_stall)

endmodule

bind single_wire_frame_transceiver_top swft_checker u_swft_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .bus_pull_low (bus_pull_low),
  .accepted     (accepted),
  .rx_byte      (rx_byte),
  .rx_valid     (rx_valid),
  .busy_res     (busy_res)
);
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

  // Mode codes the block treats as no-ops
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASE_ITEMS = 410;

  typedef enum logic [1:0] {LINK_IDLE, LINK_RX, LINK_TX} link_phase_t;
  typedef enum logic [1:0] {ROW_ONE, ROW_TICKS, ROW_RX, ROW_TX} row_kind_t;

  typedef struct packed {
    logic       bus_low;
    logic       acc;
    logic [7:0] rx_data;
    logic       rx_ok;
    logic [3:0] count;
    logic       busy;
  } link_result_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [2:0]   mode;
    logic         level;
    logic [7:0]   data;
    logic [7:0]   reps;
    logic         typed;
    link_result_t want;
  } dir_row_t;

  localparam link_result_t ALL_ZERO = '0;

  // Directed table: single transactions, tick runs and whole frames
  localparam dir_row_t DIR_ROWS [25] = '{
    '{ROW_ONE,   swft_pkg::MODE_POP,   1'b0, 8'h00, 8'd1,  1'b1, ALL_ZERO},
    '{ROW_ONE,   swft_pkg::MODE_TICK,  1'b1, 8'h00, 8'd1,  1'b1, ALL_ZERO},
    '{ROW_ONE,   swft_pkg::MODE_CLEAR, 1'b0, 8'h00, 8'd1,  1'b1, ALL_ZERO},
    '{ROW_ONE,   MODE_RSVD5,           1'b0, 8'h00, 8'd1,  1'b1, ALL_ZERO},
    '{ROW_ONE,   MODE_RSVD7,           1'b1, 8'hFF, 8'd1,  1'b1, ALL_ZERO},
    '{ROW_ONE,   swft_pkg::MODE_SEND,  1'b0, 8'h00, 8'd1,  1'b1,
      '{1'b1, 1'b1, 8'h00, 1'b0, 4'd0, 1'b1}},
    '{ROW_ONE,   swft_pkg::MODE_SEND,  1'b1, 8'hFF, 8'd1,  1'b1,
      '{1'b1, 1'b0, 8'h00, 1'b0, 4'd0, 1'b1}},
    '{ROW_ONE,   swft_pkg::MODE_EDGE,  1'b0, 8'h00, 8'd1,  1'b1,
      '{1'b1, 1'b0, 8'h00, 1'b0, 4'd0, 1'b1}},
    '{ROW_TICKS, swft_pkg::MODE_TICK,  1'b0, 8'h00, 8'd18, 1'b0, ALL_ZERO},
    '{ROW_ONE,   swft_pkg::MODE_EDGE,  1'b1, 8'h00, 8'd1,  1'b1,
      '{1'b0, 1'b1, 8'h00, 1'b0, 4'd0, 1'b1}},
    '{ROW_TICKS, swft_pkg::MODE_TICK,  1'b1, 8'h00, 8'd18, 1'b0, ALL_ZERO},
    '{ROW_ONE,   swft_pkg::MODE_SEND,  1'b0, 8'hAA, 8'd1,  1'b1,
      '{1'b1, 1'b1, 8'h00, 1'b0, 4'd1, 1'b1}},
    '{ROW_TICKS, swft_pkg::MODE_TICK,  1'b1, 8'h00, 8'd18, 1'b0, ALL_ZERO},
    '{ROW_ONE,   swft_pkg::MODE_EDGE,  1'b0, 8'h00, 8'd1,  1'b1,
      '{1'b0, 1'b1, 8'h00, 1'b0, 4'd1, 1'b1}},
    '{ROW_TICKS, swft_pkg::MODE_TICK,  1'b0, 8'h00, 8'd5,  1'b0, ALL_ZERO},
    '{ROW_ONE,   swft_pkg::MODE_CLEAR, 1'b0, 8'h00, 8'd1,  1'b1,
      '{1'b0, 1'b0, 8'h00, 1'b0, 4'd1, 1'b1}},
    '{ROW_TICKS, swft_pkg::MODE_TICK,  1'b0, 8'h00, 8'd13, 1'b0, ALL_ZERO},
    '{ROW_ONE,   swft_pkg::MODE_POP,   1'b0, 8'h00, 8'd1,  1'b0, ALL_ZERO},
    '{ROW_ONE,   swft_pkg::MODE_POP,   1'b1, 8'h00, 8'd1,  1'b1, ALL_ZERO},
    '{ROW_RX,    swft_pkg::MODE_EDGE,  1'b0, 8'h81, 8'd16, 1'b0, ALL_ZERO},
    '{ROW_ONE,   swft_pkg::MODE_POP,   1'b0, 8'h00, 8'd1,  1'b0, ALL_ZERO},
    '{ROW_ONE,   swft_pkg::MODE_POP,   1'b0, 8'h00, 8'd1,  1'b0, ALL_ZERO},
    '{ROW_ONE,   swft_pkg::MODE_CLEAR, 1'b0, 8'h00, 8'd1,  1'b0, ALL_ZERO},
    '{ROW_TX,    swft_pkg::MODE_SEND,  1'b0, 8'h80, 8'd1,  1'b0, ALL_ZERO},
    '{ROW_ONE,   MODE_RSVD6,           1'b1, 8'h5C, 8'd1,  1'b0, ALL_ZERO}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] mode = swft_pkg::MODE_TICK;
  logic       bus_level = 1'b1;
  logic [7:0] tx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       bus_pull_low;
  logic       accepted;
  logic [7:0] rx_byte;
  logic       rx_valid;
  logic [3:0] msg_count;
  logic       busy_res;

  // Predictor copy of the link state
  link_phase_t                lk_phase = LINK_IDLE;
  logic [4:0]                 lk_ticks = '0;
  logic [7:0]                 lk_rx_sr = '0;
  logic [7:0]                 lk_tx_sr = '0;
  logic                       lk_low = 1'b0;
  logic [7:0]                 lk_ring [swft_pkg::DEPTH];
  logic [swft_pkg::IDX_W-1:0] lk_rd = '0;
  logic [swft_pkg::IDX_W-1:0] lk_wr = '0;

  link_result_t pending_results [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 1'b0;
  int  quiet_cycles = 0;
  int  err_count = 0;
  int  txn_total = 0;
  int  results_checked = 0;
  int  frames_in = 0;
  int  frames_dropped = 0;
  int  bytes_popped = 0;

  single_wire_frame_transceiver_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .bus_level    (bus_level),
    .tx_byte      (tx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bus_pull_low (bus_pull_low),
    .accepted     (accepted),
    .rx_byte      (rx_byte),
    .rx_valid     (rx_valid),
    .msg_count    (msg_count),
    .busy_res     (busy_res)
  );

  always #1 clk = ~clk;

  // Advance a ring index with wrap at the depth
  function automatic logic [swft_pkg::IDX_W-1:0] ring_advance(
      input logic [swft_pkg::IDX_W-1:0] i);
    ring_advance = (int'(i) + 1 >= swft_pkg::DEPTH) ? '0 : i + 1'b1;
  endfunction

  function automatic int ring_fill();
    if (lk_wr >= lk_rd) ring_fill = int'(lk_wr) - int'(lk_rd);
    else ring_fill = swft_pkg::DEPTH - (int'(lk_rd) - int'(lk_wr));
  endfunction

  // Update the link state for one transaction and return its status
  function automatic link_result_t link_predict(input logic [2:0] m, input logic lvl,
                                                input logic [7:0] b);
    link_result_t r;
    int           cnt;
    bit           cleared;
    r = '0;
    cnt = 0;
    cleared = 1'b0;
    case (m)
      swft_pkg::MODE_TICK: begin
        if (lk_phase != LINK_IDLE) begin
          lk_ticks = lk_ticks + 5'd1;
          if (lk_phase == LINK_RX) begin
            if (lk_ticks[0] && lk_ticks >= swft_pkg::TICK_FIRST_SAMPLE &&
                lk_ticks <= swft_pkg::TICK_LAST_SAMPLE) begin
              lk_rx_sr = {lk_rx_sr[6:0], lvl};
            end else if (lk_ticks == swft_pkg::TICK_END) begin
              // commit, or drop when the ring is full
              lk_ring[lk_wr] = lk_rx_sr;
              if (ring_advance(lk_wr) != lk_rd) lk_wr = ring_advance(lk_wr);
              else frames_dropped++;
              frames_in++;
              lk_phase = LINK_IDLE;
              lk_low = 1'b0;
            end
          end else begin
            if (lk_ticks == swft_pkg::TICK_END) begin
              lk_phase = LINK_IDLE;
              lk_low = 1'b0;
            end else if (!lk_ticks[0]) begin
              lk_low = ~lk_tx_sr[7];
              lk_tx_sr = {lk_tx_sr[6:0], 1'b0};
            end
          end
        end
      end
      swft_pkg::MODE_EDGE: begin
        if (lk_phase == LINK_IDLE) begin
          lk_phase = LINK_RX;
          lk_ticks = '0;
          r.acc = 1'b1;
        end
      end
      swft_pkg::MODE_SEND: begin
        if (lk_phase == LINK_IDLE) begin
          lk_phase = LINK_TX;
          lk_ticks = '0;
          lk_tx_sr = b;
          lk_low = 1'b1;
          r.acc = 1'b1;
        end
      end
      swft_pkg::MODE_POP: begin
        if (lk_rd != lk_wr) begin
          r.rx_data = lk_ring[lk_rd];
          r.rx_ok = 1'b1;
          lk_rd = ring_advance(lk_rd);
          bytes_popped++;
        end
      end
      swft_pkg::MODE_CLEAR: begin
        cnt = ring_fill();
        lk_rd = '0;
        lk_wr = '0;
        cleared = 1'b1;
      end
      default: ;
    endcase
    if (!cleared) cnt = ring_fill();
    r.count = 4'(cnt);
    r.bus_low = lk_low;
    r.busy = (lk_phase != LINK_IDLE);
    return r;
  endfunction

  // Offer one transaction, wait for the handshake, record the expected status
  task automatic offer_txn(input logic [2:0] m, input logic lvl, input logic [7:0] b,
                           input bit typed, input link_result_t want);
    link_result_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    bus_level <= lvl;
    tx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = link_predict(m, lvl, b);
    pending_results.push_back(typed ? want : p);
    txn_total++;
  endtask

  // Stray transaction in the middle of a frame; clears kept rare
  task automatic offer_noise();
    logic [2:0] m;
    m = 3'($urandom_range(1, 7));
    if (m == swft_pkg::MODE_CLEAR && $urandom_range(7) != 0) m = swft_pkg::MODE_POP;
    offer_txn(m, 1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, ALL_ZERO);
  endtask

  // Edge plus ticks carrying byte b MSB first; noisy frames may be cut short
  task automatic rx_frame(input logic [7:0] b, input bit noisy);
    int   n;
    logic lvl;
    n = 18;
    if (noisy && $urandom_range(19) == 0) n = $urandom_range(1, 17);
    offer_txn(swft_pkg::MODE_EDGE, 1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0,
              ALL_ZERO);
    for (int t = 1; t <= n; t++) begin
      if (noisy && $urandom_range(9) == 0) offer_noise();
      lvl = (t % 2 == 1 && t >= 3) ? b[7 - (t - 3) / 2] : 1'($urandom_range(1));
      offer_txn(swft_pkg::MODE_TICK, lvl, 8'($urandom_range(255)), 1'b0, ALL_ZERO);
    end
  endtask

  task automatic tx_frame(input logic [7:0] b, input bit noisy);
    offer_txn(swft_pkg::MODE_SEND, 1'($urandom_range(1)), b, 1'b0, ALL_ZERO);
    for (int t = 1; t <= 18; t++) begin
      if (noisy && $urandom_range(9) == 0) offer_noise();
      offer_txn(swft_pkg::MODE_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0,
                ALL_ZERO);
    end
  endtask

  // Drop valid and wait until every result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  // Receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin : receiver
    int hold_left;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : monitor
    link_result_t want;
    link_result_t got;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && !out_stall) begin
        got = {bus_pull_low, accepted, rx_byte, rx_valid, msg_count, busy_res};
        if (pending_results.size() == 0) begin
          $error("result with no transaction pending");
          err_count++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          check_field("bus_pull_low", 8'(want.bus_low), 8'(got.bus_low));
          check_field("accepted", 8'(want.acc), 8'(got.acc));
          check_field("rx_byte", want.rx_data, got.rx_data);
          check_field("rx_valid", 8'(want.rx_ok), 8'(got.rx_ok));
          check_field("msg_count", 8'(want.count), 8'(got.count));
          check_field("busy_res", 8'(want.busy), 8'(got.busy));
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : stimulus
    dir_row_t   row;
    logic [2:0] m;
    int         r;
    int         stop_at;
    bit         filling;
    bit         held;
    filling = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    send_idle_pct = 24;
    recv_idle_pct = 88;
    for (int i = 0; i < 25; i++) begin
      row = DIR_ROWS[i];
      case (row.kind)
        ROW_ONE: begin
          offer_txn(row.mode, row.level, row.data, row.typed, row.want);
        end
        ROW_TICKS: begin
          repeat (int'(row.reps))
            offer_txn(swft_pkg::MODE_TICK, row.level, row.data, 1'b0, ALL_ZERO);
        end
        ROW_RX: begin
          for (int k = 0; k < int'(row.reps); k++) rx_frame(row.data + 8'(k * 29), 1'b0);
        end
        default: begin
          for (int k = 0; k < int'(row.reps); k++) tx_frame(row.data + 8'(k * 29), 1'b0);
        end
      endcase
    end
    drain_results();

    // Random part in three idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 88 : 0;
      recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 24 : 0;
      stop_at = txn_total + PHASE_ITEMS;
      held = 1'b0;
      while (txn_total < stop_at) begin
        // hold off the receiver while items keep coming at full rate
        if (ph == 2 && !held && txn_total > stop_at - PHASE_ITEMS / 2) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        // switch between filling the ring and draining it
        if ($urandom_range(24) == 0) filling = !filling;
        r = $urandom_range(99);
        if (r < 45 || (filling && r < 76)) begin
          rx_frame(8'($urandom_range(255)), 1'b1);
        end else if (r < 65) begin
          tx_frame(8'($urandom_range(255)), 1'b1);
        end else if (r < 73) begin
          offer_txn(swft_pkg::MODE_POP, 1'($urandom_range(1)), 8'($urandom_range(255)),
                    1'b0, ALL_ZERO);
        end else if (r < 75) begin
          repeat ($urandom_range(1, 17))
            offer_txn(swft_pkg::MODE_POP, 1'($urandom_range(1)), 8'($urandom_range(255)),
                      1'b0, ALL_ZERO);
        end else if (r < 76) begin
          offer_txn(swft_pkg::MODE_CLEAR, 1'($urandom_range(1)), 8'($urandom_range(255)),
                    1'b0, ALL_ZERO);
        end else begin
          m = 3'($urandom_range(7));
          if (filling && m == swft_pkg::MODE_CLEAR) m = swft_pkg::MODE_EDGE;
          offer_txn(m, 1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, ALL_ZERO);
        end
      end
      drain_results();
    end

    // Let the pipeline settle, then report
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      err_count++;
    end
    $display("testbench: %0d transactions, %0d results checked over three idle patterns",
             txn_total, results_checked);
    $display("testbench: %0d frames received, %0d dropped on a full ring, %0d bytes popped",
             frames_in, frames_dropped, bytes_popped);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
